// ----- design/echo_batch_robust_range_unit_assert.svh -----
// Assertion macros for the echo batch range unit.
// Expects signals named clk and arst_n in the scope where a macro is used.
`ifndef ECHO_BATCH_ROBUST_RANGE_UNIT_ASSERT_SVH
`define ECHO_BATCH_ROBUST_RANGE_UNIT_ASSERT_SVH

// Same-cycle implication.
`define EBRR_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ebrr: same-cycle check failed");

// Next-cycle implication.
`define EBRR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ebrr: next-cycle check failed");

`endif

// ----- design/ebrr_pkg.sv -----
// Shared constants and types for the echo batch range unit.
// No dependencies; used by every module of the block.
`default_nettype none

package ebrr_pkg;

	localparam int ECHO_W   = 17;
	localparam int DIST_W   = 12;
	localparam int BS_W     = 7;
	localparam int TRIM_W   = 5;
	localparam int SPD_W    = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 8;

	// bin = echo / 10 via reciprocal, exact for all 17-bit values
	localparam int BIN_W       = 14;
	localparam int DIV10_MUL_W = 20;
	localparam logic [DIV10_MUL_W-1:0] DIV10_MUL = 20'd838861;
	localparam int DIV10_SHIFT = 23;

	// quotient bits: one above the saturation limit
	localparam int QUO_W = DIST_W + 1;
	localparam logic [DIST_W-1:0] DIST_MAX = 12'd4095;

	localparam int MAX_BATCH_DEF  = 64;
	localparam int RANGE_BINS_DEF = 10000;

	localparam logic [BS_W-1:0]   BATCH_SIZE_RST = 7'd50;
	localparam logic [TRIM_W-1:0] TRIM_RST       = 5'd2;
	localparam logic [SPD_W-1:0]  SPEED_DIV_RST  = 8'd58;

	localparam logic [CFG_IDX_W-1:0] REG_BATCH_SIZE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TRIM_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_DIV  = 2'd2;

	typedef struct packed {
		logic              insert;
		logic              rotate;
		logic [ECHO_W-1:0] new_val;
	} ebrr_cell_ctl_t;

endpackage

`default_nettype wire

// ----- design/ebrr_cell.sv -----
// One cell of the sorting chain: holds one sample, inserts in order or rotates.
// Depends on ebrr_pkg.
`default_nettype none

module ebrr_cell (
	input  wire logic                    clk,
	input  wire ebrr_pkg::ebrr_cell_ctl_t ctl,
	input  wire logic                    occ,
	input  wire logic [ebrr_pkg::ECHO_W-1:0] left_val,
	input  wire logic                    left_gt,
	input  wire logic [ebrr_pkg::ECHO_W-1:0] right_val,
	output logic      [ebrr_pkg::ECHO_W-1:0] val,
	output logic                         gt
);
	import ebrr_pkg::*;

	logic [ECHO_W-1:0] val_q;

	assign val = val_q;
	assign gt  = occ && (val_q > ctl.new_val);

	// left neighbor moving up wins; the insertion point takes the new sample
	always_ff @(posedge clk) begin
		if (ctl.insert) begin
			if (left_gt) begin
				val_q <= left_val;
			end else if (gt || !occ) begin
				val_q <= ctl.new_val;
			end
		end else if (ctl.rotate) begin
			val_q <= right_val;
		end
	end

endmodule

`default_nettype wire

// ----- design/ebrr_div.sv -----
// Restoring divider, one quotient bit per cycle, QUO_W bits.
// Depends on ebrr_pkg. Caller keeps den below 2**(NW-QUO_W+1).
`default_nettype none

module ebrr_div #(
	parameter int NW = 36
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] num,
	input  wire logic [NW-1:0] den,
	output logic               done,
	output logic [ebrr_pkg::QUO_W-1:0] quo
);
	import ebrr_pkg::*;

	localparam int STW = $clog2(QUO_W);
	localparam logic [STW-1:0] LAST_STEP = STW'(QUO_W - 1);

	logic              busy_q;
	logic              done_q;
	logic [STW-1:0]    step_q;
	logic [NW-1:0]     rem_q;
	logic [NW-1:0]     dsh_q;
	logic [QUO_W-1:0]  quo_q;
	logic              ge;

	assign ge   = rem_q >= dsh_q;
	assign done = done_q;
	assign quo  = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + STW'(1);
				if (step_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			dsh_q <= den << (QUO_W - 1);
			quo_q <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - dsh_q;
			end
			dsh_q <= dsh_q >> 1;
			quo_q <= {quo_q[QUO_W-2:0], ge};
		end
	end

endmodule

`default_nettype wire

// ----- design/echo_batch_robust_range_unit.sv -----
// Robust ultrasonic range from a batch of echo widths. Each accepted echo is
// inserted in sorted order into a chain of MAX_BATCH cells, so while a batch
// fills the block takes one echo per cycle. When the batch is complete, input
// is held off while the chain rotates once to find the fullest 10 us bin and
// once more to sum the surviving bins, then a one-bit-per-cycle divider forms
// the distance (skipped when no sample lands in a range bin); it stays held
// off while the previous result still waits. A finished result waits in the
// output register while the next batch collects.
// Depends on ebrr_pkg, ebrr_cell, ebrr_div and the assertion macro header.
`default_nettype none
`include "echo_batch_robust_range_unit_assert.svh"

module echo_batch_robust_range_unit #(
	parameter int MAX_BATCH  = ebrr_pkg::MAX_BATCH_DEF,
	parameter int RANGE_BINS = ebrr_pkg::RANGE_BINS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration writes
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [ebrr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [ebrr_pkg::CFG_DAT_W-1:0] cfg_data,
	// echo input
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,  // [16:0] echo_us
	input  wire logic [0:0]  s_axis_tuser,  // [0] echo_lost
	// range output
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata,  // [11:0] distance_cm
	output logic [0:0]       m_axis_tuser   // [0] result_valid
);
	import ebrr_pkg::*;

	localparam int CNTW = $clog2(MAX_BATCH + 1);
	localparam int SCW  = $clog2(MAX_BATCH + 3);
	localparam int S2W  = BIN_W + CNTW;
	localparam int DW   = BIN_W + CNTW + 8;
	localparam int PW   = ECHO_W + DIV10_MUL_W;
	localparam logic [SCW-1:0] SC_LAST = SCW'(MAX_BATCH + 2);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCAN1 = 3'd1;
	localparam logic [2:0] ST_SCAN2 = 3'd2;
	localparam logic [2:0] ST_MUL   = 3'd3;
	localparam logic [2:0] ST_START = 3'd4;
	localparam logic [2:0] ST_DIV   = 3'd5;
	localparam logic [2:0] ST_DONE  = 3'd6;

	logic [2:0]        state_q;
	logic [BS_W-1:0]   bs_q;
	logic [TRIM_W-1:0] trim_q;
	logic [SPD_W-1:0]  spd_q;
	logic [CNTW-1:0]   count_q;
	logic [CNTW-1:0]   n_q;
	logic [SCW-1:0]    sc_q;

	logic              s_fire;
	logic              finish;
	logic [CNTW-1:0]   eff;
	logic [CNTW-1:0]   cnt_inc;
	logic              scanning;

	// sorting chain
	ebrr_cell_ctl_t    cell_ctl;
	logic [ECHO_W-1:0] vals [MAX_BATCH];
	logic [ECHO_W-1:0] lvals [MAX_BATCH];
	logic [ECHO_W-1:0] rvals [MAX_BATCH];
	logic [MAX_BATCH-1:0] gts;
	logic [MAX_BATCH-1:0] lgts;
	logic [MAX_BATCH-1:0] occ;

	// scan pipeline
	logic              vld_s1, keep_s1, vld_s2, keep_s2;
	logic [ECHO_W-1:0] v_s1;
	logic [BIN_W-1:0]  bin_s2;
	logic [PW-1:0]     bin_prod;
	logic              keep_now;
	logic              kept;
	logic              flush;
	logic              close;

	logic              run_act_q;
	logic [BIN_W-1:0]  cur_bin_q;
	logic [CNTW-1:0]   run_q;
	logic [S2W-1:0]    rsum_q;
	logic [CNTW-1:0]   maxc_q;
	logic [CNTW-1:0]   sum1_q;
	logic [S2W-1:0]    sum2_q;

	logic [SPD_W-1:0]  deff;
	logic [SPD_W+CNTW-1:0] prod_q;
	logic [DW-1:0]     div_num, div_den;
	logic              div_start, div_done;
	logic [QUO_W-1:0]  div_quo;

	logic              ov_q;
	logic [DIST_W-1:0] res_dist_q, out_dist_q;
	logic              res_vld_q, out_vld_q;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign s_fire        = s_axis_tvalid && s_axis_tready;
	assign scanning      = (state_q == ST_SCAN1) || (state_q == ST_SCAN2);

	always_comb begin
		if (bs_q == '0) begin
			eff = CNTW'(1);
		end else if (32'(bs_q) > 32'(MAX_BATCH)) begin
			eff = CNTW'(MAX_BATCH);
		end else begin
			eff = CNTW'(bs_q);
		end
	end

	assign cnt_inc = count_q + CNTW'(1);
	assign finish  = s_fire && (cnt_inc >= eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bs_q   <= BATCH_SIZE_RST;
			trim_q <= TRIM_RST;
			spd_q  <= SPEED_DIV_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_BATCH_SIZE: bs_q   <= cfg_data[BS_W-1:0];
				REG_TRIM_COUNT: trim_q <= cfg_data[TRIM_W-1:0];
				REG_SPEED_DIV:  spd_q  <= cfg_data[SPD_W-1:0];
				default: ;
			endcase
		end
	end

	assign cell_ctl.insert  = s_fire;
	assign cell_ctl.rotate  = scanning && (32'(sc_q) < 32'(MAX_BATCH));
	assign cell_ctl.new_val = s_axis_tuser[0] ? '0 : s_axis_tdata[ECHO_W-1:0];

	for (genvar i = 0; i < MAX_BATCH; i++) begin : g_cell
		localparam logic [CNTW-1:0] IDX = CNTW'(i);
		assign occ[i] = count_q > IDX;
		if (i == 0) begin : g_head
			assign lvals[i] = '0;
			assign lgts[i]  = 1'b0;
		end else begin : g_mid
			assign lvals[i] = vals[i-1];
			assign lgts[i]  = gts[i-1];
		end
		if (i == MAX_BATCH - 1) begin : g_tail
			assign rvals[i] = vals[0];
		end else begin : g_body
			assign rvals[i] = vals[i+1];
		end
		ebrr_cell u_cell (
			.clk       (clk),
			.ctl       (cell_ctl),
			.occ       (occ[i]),
			.left_val  (lvals[i]),
			.left_gt   (lgts[i]),
			.right_val (rvals[i]),
			.val       (vals[i]),
			.gt        (gts[i])
		);
	end

	// trimmed window: trim <= k < n - trim
	assign keep_now = (32'(sc_q) >= 32'(trim_q)) && (32'(sc_q) + 32'(trim_q) < 32'(n_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= cell_ctl.rotate;
			vld_s2 <= vld_s1;
		end
	end

	assign bin_prod = PW'(v_s1) * PW'(DIV10_MUL);

	always_ff @(posedge clk) begin
		v_s1    <= vals[0];
		keep_s1 <= keep_now;
		bin_s2  <= BIN_W'(bin_prod >> DIV10_SHIFT);
		keep_s2 <= keep_s1;
	end

	assign kept  = vld_s2 && keep_s2 && (32'(bin_s2) < 32'(RANGE_BINS));
	assign flush = scanning && (sc_q == SC_LAST);
	assign close = run_act_q && (flush || (kept && (bin_s2 != cur_bin_q)));

	assign deff    = (spd_q == '0) ? SPD_W'(1) : spd_q;
	assign div_num = (DW'(sum2_q) << 4) + (DW'(sum2_q) << 2) + DW'(prod_q);
	assign div_den = DW'(prod_q) << 1;
	assign div_start = (state_q == ST_START);

	ebrr_div #(
		.NW (DW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			sc_q      <= '0;
			run_act_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (finish) begin
						count_q   <= '0;
						sc_q      <= '0;
						run_act_q <= 1'b0;
						state_q   <= ST_SCAN1;
					end else if (s_fire) begin
						count_q <= cnt_inc;
					end
				end
				ST_SCAN1, ST_SCAN2: begin
					if (flush) begin
						sc_q      <= '0;
						run_act_q <= 1'b0;
						state_q   <= (state_q == ST_SCAN1) ? ST_SCAN2 : ST_MUL;
					end else begin
						sc_q <= sc_q + SCW'(1);
						if (kept) begin
							run_act_q <= 1'b1;
						end
					end
				end
				ST_MUL: begin
					state_q <= (sum1_q == '0) ? ST_DONE : ST_START;
				end
				ST_START: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!ov_q || m_axis_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// run tracking over the sorted, trimmed stream, plus divider operand, result and output registers
	always_ff @(posedge clk) begin
		if (finish) begin
			n_q    <= cnt_inc;
			maxc_q <= '0;
			sum1_q <= '0;
			sum2_q <= '0;
		end
		if (kept) begin
			if (run_act_q && (bin_s2 == cur_bin_q)) begin
				run_q  <= run_q + CNTW'(1);
				rsum_q <= rsum_q + S2W'(bin_s2);
			end else begin
				cur_bin_q <= bin_s2;
				run_q     <= CNTW'(1);
				rsum_q    <= S2W'(bin_s2);
			end
		end
		if (close) begin
			if (state_q == ST_SCAN1) begin
				if (run_q > maxc_q) begin
					maxc_q <= run_q;
				end
			end else if ({run_q, 1'b0} >= {1'b0, maxc_q}) begin
				sum1_q <= sum1_q + run_q;
				sum2_q <= sum2_q + rsum_q;
			end
		end
		if (state_q == ST_MUL) begin
			prod_q     <= (SPD_W+CNTW)'(deff) * (SPD_W+CNTW)'(sum1_q);
			res_dist_q <= '0;
			res_vld_q  <= 1'b0;
		end
		if (div_done) begin
			res_dist_q <= div_quo[QUO_W-1] ? DIST_MAX : div_quo[DIST_W-1:0];
			res_vld_q  <= 1'b1;
		end
		if ((state_q == ST_DONE) && (!ov_q || m_axis_tready)) begin
			out_dist_q <= res_dist_q;
			out_vld_q  <= res_vld_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if ((state_q == ST_DONE) && (!ov_q || m_axis_tready)) begin
			ov_q <= 1'b1;
		end else if (m_axis_tready) begin
			ov_q <= 1'b0;
		end
	end

	assign m_axis_tvalid   = ov_q;
	assign m_axis_tdata    = {{(16 - DIST_W){1'b0}}, out_dist_q};
	assign m_axis_tuser[0] = out_vld_q;

	`EBRR_ASSERT_IMP(a_count_bound, state_q == ST_IDLE, 32'(count_q) < 32'(MAX_BATCH))
	`EBRR_ASSERT_NEXT(a_finish_scan, finish, (state_q == ST_SCAN1) && (count_q == '0))
	`EBRR_ASSERT_IMP(a_div_in_state, div_done, state_q == ST_DIV)
	`EBRR_ASSERT_IMP(a_no_insert_scan, scanning, !cell_ctl.insert)
	`EBRR_ASSERT_IMP(a_invalid_zero, m_axis_tvalid && !m_axis_tuser[0], out_dist_q == '0)

endmodule

`default_nettype wire
